>>> sv/utf16_to_utf8_transcoder_defines.svh
// assertion macros shared by the checker
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, sampled on aclk outside reset
`define U16U8_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("u16u8 check failed");

// next-cycle implication, sampled on aclk outside reset
`define U16U8_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("u16u8 check failed");

`endif

>>> sv/u16u8_pkg.sv
package u16u8_pkg;

    localparam int unsigned MAX_BYTES   = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [5:0]  HIGH_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_TAG   = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0]  LEAD2     = 8'hc0;
    localparam logic [7:0]  LEAD3     = 8'he0;
    localparam logic [7:0]  LEAD4     = 8'hf0;
    localparam logic [7:0]  CONT      = 8'h80;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      final_unit;
    } job_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } bmp_enc_t;

    function automatic bmp_enc_t encode_bmp(input logic [15:0] u);
        bmp_enc_t e;
        e = '0;
        if (u[15:7] == 9'd0) begin
            e.bytes[0] = {1'b0, u[6:0]};
            e.count    = 2'd1;
        end else if (u[15:11] == 5'd0) begin
            e.bytes[0] = LEAD2 | {3'b000, u[10:6]};
            e.bytes[1] = CONT | {2'b00, u[5:0]};
            e.count    = 2'd2;
        end else begin
            e.bytes[0] = LEAD3 | {4'b0000, u[15:12]};
            e.bytes[1] = CONT | {2'b00, u[11:6]};
            e.bytes[2] = CONT | {2'b00, u[5:0]};
            e.count    = 2'd3;
        end
        return e;
    endfunction

endpackage

>>> sv/u16u8_front.sv
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [15:0] code_unit,
    input  logic        unit_is_final,
    output logic        push,
    output job_t        push_job
);

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_bits_reg, held_bits_next;

    logic        is_high, is_low, pair, emit_unit;
    logic [20:0] cp;
    bmp_enc_t    held_enc, unit_enc;

    assign is_high = (code_unit[15:10] == HIGH_TAG);
    assign is_low  = (code_unit[15:10] == LOW_TAG);
    assign pair    = held_valid_reg && is_low;
    assign cp      = SUPP_BASE + {1'b0, held_bits_reg, code_unit[9:0]};
    assign emit_unit = !(is_high && !unit_is_final);
    assign held_enc  = encode_bmp({HIGH_TAG, held_bits_reg});
    assign unit_enc  = encode_bmp(code_unit);

    always_comb begin
        push_job = '0;
        push_job.final_unit = unit_is_final;
        if (pair) begin
            push_job.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            push_job.bytes[1] = CONT | {2'b00, cp[17:12]};
            push_job.bytes[2] = CONT | {2'b00, cp[11:6]};
            push_job.bytes[3] = CONT | {2'b00, cp[5:0]};
            push_job.count    = 3'd4;
        end else if (held_valid_reg) begin
            push_job.bytes[2:0] = held_enc.bytes;
            push_job.bytes[5:3] = unit_enc.bytes;
            push_job.count      = emit_unit ? 3'd3 + {1'b0, unit_enc.count} : 3'd3;
        end else begin
            push_job.bytes[2:0] = unit_enc.bytes;
            push_job.count      = emit_unit ? {1'b0, unit_enc.count} : 3'd0;
        end
    end

    assign push = accept && (push_job.count != 3'd0);

    always_comb begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept) begin
            if (!pair && !emit_unit) begin
                held_valid_next = 1'b1;
                held_bits_next  = code_unit[9:0];
            end else begin
                held_valid_next = 1'b0;
                held_bits_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

>>> sv/u16u8_queue.sv
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/u16u8_back.sv
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       byte_is_final
);

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       last_byte, done;

    assign last_byte     = (idx_reg == cur_reg.count - 3'd1);
    assign done          = out_valid && out_ready && last_byte;
    assign pop           = head_valid && (!cur_valid_reg || done);
    assign out_valid     = cur_valid_reg;
    assign out_byte      = cur_reg.bytes[idx_reg];
    assign run_last      = last_byte;
    assign byte_is_final = last_byte && cur_reg.final_unit;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (done) begin
            cur_valid_next = 1'b0;
            idx_next       = '0;
        end else if (out_valid && out_ready) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

>>> sv/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. One code unit enters per s_axis transfer (tlast marks the last
// unit of the string) and its UTF-8 bytes leave one per m_axis transfer; m_axis_tlast marks the
// last byte caused by a unit and m_axis_tuser marks the last byte of the string. A high surrogate
// not on the final unit is held for the next unit; a following low surrogate makes one four-byte
// sequence, else it is flushed as three bytes first. Lone surrogates are encoded, not replaced.
// A unit is taken every cycle while the two-entry job queue has room; the output side sends one
// byte per cycle while m_axis_tready is high, and a unit yields 0 to 6 bytes.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // code_unit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser   // byte_is_final
);

    logic accept, push, pop, full, head_valid;
    job_t push_job, head_job;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    u16u8_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .code_unit     (s_axis_tdata),
        .unit_is_final (s_axis_tlast),
        .push          (push),
        .push_job      (push_job)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .run_last      (m_axis_tlast),
        .byte_is_final (m_axis_tuser[0])
    );

endmodule

>>> sv/u16u8_checker.sv
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    logic out_xfer;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // end of string only on the last byte of a run
    `U16U8_ASSERT_NOW(a_final_is_run_end, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

    // no byte value from f8 to ff, which utf-8 never uses
    `U16U8_ASSERT_NOW(a_legal_byte, out_xfer, m_axis_tdata[7:3] != 5'b11111)

    // a stalled output keeps its valid
    `U16U8_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a stalled output keeps its byte
    `U16U8_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // input stalls only while a byte is waiting
    `U16U8_ASSERT_NOW(a_stall_has_output, s_axis_tvalid && !s_axis_tready, m_axis_tvalid)

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [15:0] HI_FIRST   = 16'hd800;
    localparam logic [15:0] HI_LAST    = 16'hdbff;
    localparam logic [15:0] LO_FIRST   = 16'hdc00;
    localparam logic [15:0] LO_LAST    = 16'hdfff;
    localparam logic [20:0] SUPP_FIRST = 21'h10000;
    localparam logic [20:0] SUPP_LAST  = 21'h10ffff;
    localparam int          STALL_LIMIT = 1000;
    localparam int          HOLD_CYCLES = 80;
    localparam int          IDLE_PCT    = 37;
    localparam int          RANDOM_UNITS = 90;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_final;
    } utf8_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // code_unit
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_byte
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;   // byte_is_final

    utf8_byte_t  utf8_expected[$];
    logic [7:0]  utf8_run[$];
    logic        held_hi_valid;
    logic [9:0]  held_hi_bits;

    int          error_count;
    int          units_sent;
    int          pairs_sent;
    int          bytes_checked;
    int          sender_idle_pct;
    int          rx_idle_pct;
    int          hold_req;
    int          hold_done;
    int          hold_left;
    int          quiet_cycles;

    utf16_to_utf8_transcoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic void add_run_byte(input logic [7:0] b);
        utf8_run.insert(utf8_run.size(), b);
    endfunction

    function automatic void append_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            add_run_byte(cp[7:0]);
        end else if (cp <= 21'h7ff) begin
            add_run_byte(8'hc0 | {3'b000, cp[10:6]});
            add_run_byte(8'h80 | {2'b00, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            add_run_byte(8'he0 | {4'b0000, cp[15:12]});
            add_run_byte(8'h80 | {2'b00, cp[11:6]});
            add_run_byte(8'h80 | {2'b00, cp[5:0]});
        end else begin
            add_run_byte(8'hf0 | {5'b00000, cp[20:18]});
            add_run_byte(8'h80 | {2'b00, cp[17:12]});
            add_run_byte(8'h80 | {2'b00, cp[11:6]});
            add_run_byte(8'h80 | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic void predict_utf8(input logic [15:0] u, input logic fin);
        logic       is_hi;
        logic       is_lo;
        logic       paired;
        utf8_byte_t b;
        int         i;
        is_hi = (u >= HI_FIRST) && (u <= HI_LAST);
        is_lo = (u >= LO_FIRST) && (u <= LO_LAST);
        paired = 1'b0;
        utf8_run.delete();
        if (held_hi_valid) begin
            held_hi_valid = 1'b0;
            if (is_lo) begin
                append_utf8(SUPP_FIRST + {1'b0, held_hi_bits, u[9:0]});
                paired = 1'b1;
            end else begin
                append_utf8({5'd0, HI_FIRST[15:10], held_hi_bits});
            end
            held_hi_bits = '0;
        end
        if (!paired) begin
            if (is_hi && !fin) begin
                held_hi_valid = 1'b1;
                held_hi_bits  = u[9:0];
            end else begin
                append_utf8({5'd0, u});
            end
        end
        for (i = 0; i < utf8_run.size(); i++) begin
            b.data      = utf8_run[i];
            b.run_last  = (i == utf8_run.size() - 1);
            b.str_final = b.run_last && fin;
            utf8_expected.insert(utf8_expected.size(), b);
        end
    endfunction

    task automatic send_unit(input logic [15:0] u, input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= u;
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        predict_utf8(u, fin);
        units_sent++;
        @(negedge aclk);
    endtask

    task automatic send_point(input logic [20:0] cp, input logic fin);
        logic [19:0] off;
        if (cp >= SUPP_FIRST) begin
            off = 20'(cp - SUPP_FIRST);
            pairs_sent++;
            send_unit(HI_FIRST | {6'd0, off[19:10]}, 1'b0);
            send_unit(LO_FIRST | {6'd0, off[9:0]}, fin);
        end else begin
            send_unit(cp[15:0], fin);
        end
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (utf8_expected.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_bmp_boundaries();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b1);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hffff, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_point(SUPP_FIRST, 1'b0);
        send_point(SUPP_LAST, 1'b1);
        send_point(21'h1f600, 1'b0);
    endtask

    task automatic test_lone_surrogates();
        // low with nothing held, then on the final unit
        send_unit(LO_FIRST, 1'b0);
        send_unit(LO_LAST, 1'b1);
        // held high flushed by ascii
        send_unit(HI_FIRST, 1'b0);
        send_unit(16'h0041, 1'b0);
        // held high flushed by another high, which then pairs
        send_unit(HI_LAST, 1'b0);
        send_unit(HI_FIRST, 1'b0);
        send_unit(LO_FIRST, 1'b0);
        // high on the final unit goes out at once
        send_unit(16'hd801, 1'b1);
        // flush plus final high: six bytes from one unit
        send_unit(16'hd802, 1'b0);
        send_unit(16'hdbfe, 1'b1);
    endtask

    task automatic test_output_stall();
        int k;
        hold_req++;
        for (k = 0; k < 24; k++) begin
            if (k % 2 == 0)
                send_point(21'($urandom_range(SUPP_FIRST, SUPP_LAST)), k == 23);
            else
                send_unit(16'($urandom_range(16'h0800, 16'hd7ff)), 1'b0);
        end
        wait_for_drain();
    endtask

    task automatic test_random_strings();
        int       start;
        int       len;
        int       k;
        int       sel;
        logic     fin;
        logic [15:0] u;
        bit       drained;
        start = units_sent;
        drained = 0;
        sender_idle_pct = 0;
        rx_idle_pct = 0;
        while (units_sent - start < RANDOM_UNITS) begin
            if (units_sent - start >= 40) begin
                sender_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (!drained && units_sent - start >= 70) begin
                wait_for_drain();
                drained = 1;
            end
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
                sel = $urandom_range(99);
                fin = (k == len - 1);
                if (sel < 40) begin
                    send_unit(16'($urandom_range(16'h0000, 16'h007f)), fin);
                end else if (sel < 55) begin
                    send_unit(16'($urandom_range(16'h0080, 16'h07ff)), fin);
                end else if (sel < 70) begin
                    if ($urandom_range(1))
                        u = 16'($urandom_range(16'h0800, 16'hd7ff));
                    else
                        u = 16'($urandom_range(16'he000, 16'hffff));
                    send_unit(u, fin);
                end else if (sel < 90) begin
                    send_point(21'($urandom_range(SUPP_FIRST, SUPP_LAST)), fin);
                end else if (sel < 95) begin
                    send_unit(16'($urandom_range(HI_FIRST, LO_LAST)), fin);
                end else begin
                    send_unit(16'($urandom()), fin);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random stalls plus a long hold-off when a test requests one
    initial begin
        m_axis_tready = 1'b0;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_done != hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_req;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        utf8_byte_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (utf8_expected.size() == 0) begin
                $error("unexpected transfer: out_byte %h", m_axis_tdata);
                error_count++;
            end else begin
                e = utf8_expected.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== e.data) begin
                    $error("out_byte expected %h actual %h", e.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== e.run_last) begin
                    $error("run_last expected %b actual %b", e.run_last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser[0] !== e.str_final) begin
                    $error("byte_is_final expected %b actual %b", e.str_final,
                           m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        held_hi_valid = 1'b0;
        held_hi_bits = '0;
        error_count = 0;
        units_sent = 0;
        pairs_sent = 0;
        bytes_checked = 0;
        quiet_cycles = 0;
        hold_req = 0;
        sender_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_bmp_boundaries();
        test_surrogate_pairs();
        test_lone_surrogates();
        wait_for_drain();
        test_output_stall();
        test_random_strings();

        while (utf8_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (utf8_expected.size() != 0) begin
            $error("%0d expected bytes never arrived", utf8_expected.size());
            error_count++;
        end
        $display("sent %0d code units (%0d surrogate pairs), checked %0d utf-8 bytes",
                 units_sent, pairs_sent, bytes_checked);
        $display("covered bmp edges, pairs, lone and flushed surrogates, long output stall");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
